### rtl/aesbe_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 encryption package
// Shared types, S-box table and GF(2^8) helpers for the byte-serial core.
// ----------------------------------------------------------------------------
package aesbe_pkg;

    localparam int unsigned ROUNDS = 10;

    // Configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Control from the sequencer to the data and key paths
    typedef struct packed {
        logic       load;
        logic       sub;
        logic       mix;
        logic       last;
        logic [3:0] cnt;
    } t_ctl;

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col);
        logic [7:0] a0, a1, a2, a3, all;
        a0  = col[31:24];
        a1  = col[23:16];
        a2  = col[15:8];
        a3  = col[7:0];
        all = a0 ^ a1 ^ a2 ^ a3;
        mix_col = {a0 ^ all ^ gf_double(a0 ^ a1),
                   a1 ^ all ^ gf_double(a1 ^ a2),
                   a2 ^ all ^ gf_double(a2 ^ a3),
                   a3 ^ all ^ gf_double(a3 ^ a0)};
    endfunction

endpackage

### rtl/aesbe_keysched.sv
// ----------------------------------------------------------------------------
// AES-128 round key generator
// Derives each round key on the fly, one S-box byte then one word per cycle.
// ----------------------------------------------------------------------------
module aesbe_keysched import aesbe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  logic [127:0] i_key,
    output logic [31:0]  o_word
);

    logic [127:0] r_rk;
    logic [31:0]  r_kt;
    logic [7:0]   r_rc;
    logic [31:0]  rot;
    logic [7:0]   kbyte;
    logic [31:0]  nw;

    // RotWord of the last word, picked a byte at a time
    assign rot   = {r_rk[23:0], r_rk[31:24]};
    assign kbyte = rot[8 * (2'd3 - i_ctl.cnt[1:0]) +: 8];
    assign nw    = r_rk[127:96] ^ ((i_ctl.cnt == 4'd0) ? (r_kt ^ {r_rc, 24'h0})
                                                        : r_rk[31:0]);
    assign o_word = nw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= 8'h01;
        end else if (i_ctl.load) begin
            r_rc <= 8'h01;
        end else if (i_ctl.mix && i_ctl.cnt == 4'd3) begin
            r_rc <= gf_double(r_rc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rk <= i_key;
        end else if (i_ctl.mix) begin
            r_rk <= {r_rk[95:0], nw};
        end
        if (i_ctl.sub && i_ctl.cnt < 4'd4) begin
            r_kt <= {r_kt[23:0], SBOX[kbyte]};
        end
    end

endmodule

### rtl/aesbe_datapath.sv
// ----------------------------------------------------------------------------
// AES-128 byte-serial state path
// SubBytes and ShiftRows a byte per cycle, MixColumns (not in the last round)
// and key add a column per cycle.
// ----------------------------------------------------------------------------
module aesbe_datapath import aesbe_pkg::*; (
    input  logic         i_clk,
    input  t_ctl         i_ctl,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    input  logic [31:0]  i_word,
    output logic [127:0] o_state
);

    logic [15:0][7:0] r_st;
    logic [127:0]     r_tmp;
    logic [1:0]       col_src;
    logic [3:0]       src;
    logic [31:0]      col;
    logic [31:0]      mc;

    // ShiftRows: byte (c,r) comes from column c+r of row r
    assign col_src = i_ctl.cnt[3:2] + i_ctl.cnt[1:0];
    assign src     = {col_src, i_ctl.cnt[1:0]};
    assign col     = r_tmp[127:96];
    assign mc      = i_ctl.last ? col : mix_col(col);
    assign o_state = r_st;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_st <= i_block ^ i_key;
        end else if (i_ctl.mix) begin
            r_st <= {r_st[11:0], mc ^ i_word};
        end
        if (i_ctl.sub) begin
            r_tmp <= {r_tmp[119:0], SBOX[r_st[4'd15 - src]]};
        end else if (i_ctl.mix) begin
            r_tmp <= {r_tmp[95:0], 32'h0};
        end
    end

endmodule

### rtl/aes128_block_encrypt.sv
// Flow: after the accepting edge, each of the 10 rounds feeds the 16 state bytes
// through one S-box and then handles the 4 columns; then one unload moves the result.
// No new item is accepted until that unload has returned the sequencer to idle.
// Reset (synchronous, active low) clears both key registers to zero, the
// sequencer and the output valid.
// ----------------------------------------------------------------------------
// AES-128 block encryption, top level
// Sequencer, key registers and output register around the byte-serial core.
// ----------------------------------------------------------------------------
module aes128_block_encrypt import aesbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SUB, S_MIX, S_DONE} t_state;

    t_state       r_state;
    logic [3:0]   r_cnt;
    logic [3:0]   r_round;
    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_ov;
    logic [63:0]  r_out_high;
    logic [63:0]  r_out_low;
    logic         accept;
    logic         unload;
    t_ctl         ctl;
    logic [31:0]  word;
    logic [127:0] state_q;

    assign o_in_stall    = (r_state != S_IDLE);
    assign accept        = i_in_valid && !o_in_stall;
    // Finished state moves out once the output register is free
    assign unload        = (r_state == S_DONE) && (!r_ov || !i_out_stall);
    assign o_out_valid   = r_ov;
    assign o_cipher_high = r_out_high;
    assign o_cipher_low  = r_out_low;

    assign ctl.load = accept;
    assign ctl.sub  = (r_state == S_SUB);
    assign ctl.mix  = (r_state == S_MIX);
    assign ctl.last = (r_round == 4'(ROUNDS));
    assign ctl.cnt  = r_cnt;

    // Key registers: the user must write them only while idle; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= 64'h0;
            r_key_low  <= 64'h0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Sequencer: per round, the 16 state bytes through S_SUB, then the 4 columns through S_MIX
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 4'd0;
            r_round <= 4'd1;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SUB;
                        r_cnt   <= 4'd0;
                        r_round <= 4'd1;
                    end
                end
                S_SUB: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (r_cnt == 4'd3) begin
                        r_cnt <= 4'd0;
                        if (ctl.last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_round <= r_round + 4'd1;
                            r_state <= S_SUB;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DONE: begin
                    if (unload) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Hold the result until the item is taken
    always_ff @(posedge i_clk) begin
        if (unload) begin
            r_out_high <= state_q[127:64];
            r_out_low  <= state_q[63:0];
        end
    end

    aesbe_keysched u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_key   ({r_key_high, r_key_low}),
        .o_word  (word)
    );

    aesbe_datapath u_dp (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_block ({i_block_high, i_block_low}),
        .i_key   ({r_key_high, r_key_low}),
        .i_word  (word),
        .o_state (state_q)
    );

endmodule

### rtl/aesbe_checker.sv
// ----------------------------------------------------------------------------
// AES-128 encryption port checker
// Watches the top-level ports over time and flags handshake slips.
// ----------------------------------------------------------------------------
module aesbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_cipher_high,
    input logic [63:0] o_cipher_low
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cipher_high)
                                       && $stable(o_cipher_low))
        else $error("stalled result item changed");

    // An accepted item blocks further input while it is worked on
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted during encryption");

    // A new result only appears when a busy block finishes
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item without work in progress");

endmodule

bind aes128_block_encrypt aesbe_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cipher_high (o_cipher_high),
    .o_cipher_low  (o_cipher_low)
);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Drives plaintext items under random idling, predicts ciphertext with an
// independent cipher model and compares results field by field.
// ----------------------------------------------------------------------------
module testbench import aesbe_pkg::*;;

    localparam int LATENCY      = 210;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_blk;

    typedef struct {
        t_blk plain;
        bit   known;
        t_blk cipher;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_cipher_high;
    logic [63:0] o_cipher_low;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    aes128_block_encrypt dut (.*);

    // Own copy of the S-box, so the predictor does not share the RTL's S-box table
    byte unsigned sbox_copy [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    logic [63:0] key_hi_q, key_lo_q;
    logic [31:0] sched [4*(ROUNDS+1)];
    t_blk        cipher_due [$];
    int          fails = 0, mismatches = 0, cycles = 0;
    int          send_idle_pct, recv_idle_pct;

    function automatic logic [7:0] xtime(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Rebuild the round key words from the two key registers
    function automatic void rebuild_schedule();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        sched[0] = key_hi_q[63:32];
        sched[1] = key_hi_q[31:0];
        sched[2] = key_lo_q[63:32];
        sched[3] = key_lo_q[31:0];
        for (int i = 4; i < 4*(ROUNDS+1); i++) begin
            t = sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sbox_copy[t[31:24]], sbox_copy[t[23:16]],
                     sbox_copy[t[15:8]], sbox_copy[t[7:0]]} ^ {rcon, 24'h0};
                rcon = xtime(rcon);
            end
            sched[i] = sched[i-4] ^ t;
        end
    endfunction

    function automatic t_blk encrypt_block(t_blk p);
        logic [7:0] st [16];
        logic [7:0] nx [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] flat;
        t_blk r;
        flat = {p.hi, p.lo};
        for (int i = 0; i < 16; i++) st[i] = flat[127-8*i -: 8];
        for (int rnd = 0; rnd <= ROUNDS; rnd++) begin
            if (rnd > 0) begin
                // substitute and shift rows in one pass
                for (int c = 0; c < 4; c++)
                    for (int rw = 0; rw < 4; rw++)
                        nx[4*c+rw] = sbox_copy[st[4*((c+rw)%4)+rw]];
                st = nx;
                if (rnd < ROUNDS) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                        st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                        st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                        st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int rw = 0; rw < 4; rw++)
                    st[4*c+rw] ^= sched[rnd*4+c][31-8*rw -: 8];
        end
        for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = st[i];
        r.hi = flat[127:64];
        r.lo = flat[63:0];
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Write one key register while the block is idle and mirror it
    task automatic write_key(logic idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_KEY_HIGH) key_hi_q = val;
        else key_lo_q = val;
        rebuild_schedule();
    endtask

    // Drop valid, hold until every expected result is in, then let the engine settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (cipher_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Present one item; a known cipher value overrides the prediction
    task automatic send_item(t_blk p, bit known, t_blk c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_block_high <= p.hi;
        i_block_low  <= p.lo;
        do @(posedge i_clk); while (o_in_stall);
        cipher_due.push_back(known ? c : encrypt_block(p));
        @(negedge i_clk);
    endtask

    function automatic t_blk rand_blk(int shape);
        t_blk b;
        b.hi = {$urandom, $urandom};
        b.lo = {$urandom, $urandom};
        case (shape)
            0: b.hi = '0;
            1: b.lo = '1;
            2: b = b & {2{64'h00ff_00ff_00ff_00ff}};
            default: ;
        endcase
        return b;
    endfunction

    // Receiver: random stall, compare the oldest expectation
    always @(negedge i_clk) begin
        if (i_rst_n) i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_blk want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_due.size() == 0) begin
                fails++;
                if (mismatches++ < 10) $display("unexpected result %h %h", o_cipher_high, o_cipher_low);
            end else begin
                want = cipher_due.pop_front();
                if (want.hi !== o_cipher_high || want.lo !== o_cipher_low) begin
                    fails++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %h %h got %h %h",
                                 want.hi, want.lo, o_cipher_high, o_cipher_low);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        t_row  rows [$];
        t_blk  zero_b, ones_b;
        logic [63:0] keys [4];
        send_idle_pct = 0; recv_idle_pct = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_block_high = '0; i_block_low = '0;
        i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        key_hi_q = '0; key_lo_q = '0;
        rebuild_schedule();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: all-zero key straight from reset, then the FIPS-197 key, then an all-ones key
        zero_b = '0;
        ones_b = '1;
        rows.push_back('{zero_b, 1'b1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
        rows.push_back('{ones_b, 1'b0, zero_b});
        rows.push_back('{'{64'h8000000000000000, 64'h0}, 1'b0, zero_b});
        rows.push_back('{'{64'h0, 64'h1}, 1'b0, zero_b});
        rows.push_back('{'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 1'b0, zero_b});
        foreach (rows[i]) send_item(rows[i].plain, rows[i].known, rows[i].cipher);
        drain();

        write_key(CFG_KEY_HIGH, 64'h0001020304050607);
        write_key(CFG_KEY_LOW,  64'h08090a0b0c0d0e0f);
        send_item('{64'h0011223344556677, 64'h8899aabbccddeeff}, 1'b1,
                  '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
        send_item(ones_b, 1'b0, zero_b);
        send_item(zero_b, 1'b0, zero_b);
        drain();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW,  '1);
        send_item(zero_b, 1'b0, zero_b);
        send_item(ones_b, 1'b0, zero_b);
        drain();

        // Random part in three idling phases, keys changed between bursts
        keys[0] = '0; keys[1] = '1;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 30 : 0;
            for (int burst = 0; burst < 10; burst++) begin
                drain();
                keys[2] = {$urandom, $urandom};
                keys[3] = {$urandom, $urandom};
                write_key(CFG_KEY_HIGH, keys[$urandom_range(3)]);
                write_key(CFG_KEY_LOW,  keys[$urandom_range(3)]);
                for (int n = 0; n < 50; n++) send_item(rand_blk($urandom_range(5)), 1'b0, zero_b);
            end
        end
        drain();
        if (fails == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
